/* hdl/sfcd_pkg.sv */
`timescale 1ns / 1ps

package sfcd_pkg;

    localparam int FRAME_LEN  = 32;
    localparam int CMD_LEN    = 16;
    localparam int CMD_OFFSET = 6;

    localparam int POS_W = $clog2(FRAME_LEN);
    localparam int IDX_W = 6;

    // Chain cell that holds the first command byte once a frame is complete.
    localparam int TAP = FRAME_LEN - 1 - CMD_OFFSET;

    localparam logic [7:0] SYNC_A = 8'hAB;
    localparam logic [7:0] SYNC_B = 8'hCD;
    localparam logic [7:0] TAIL_A = 8'hDC;
    localparam logic [7:0] TAIL_B = 8'hBA;

    localparam logic [POS_W-1:0] POS_TAIL_A = POS_W'(FRAME_LEN - 2);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(CMD_LEN - 1);

    typedef enum logic [2:0] {
        STAT_NONE      = 3'd0,
        STAT_CMD       = 3'd1,
        STAT_BAD_SYNC  = 3'd2,
        STAT_BAD_TAIL1 = 3'd3,
        STAT_BAD_TAIL2 = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        ST_HUNT  = 4'b0001,
        ST_SYNC2 = 4'b0010,
        ST_BODY  = 4'b0100,
        ST_TAIL2 = 4'b1000
    } t_state;

    typedef struct packed {
        logic       shift;
        logic [7:0] din;
    } t_chain_ctl;

endpackage

/* hdl/sfcd_cell.sv */
`timescale 1ns / 1ps

module sfcd_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_din,
    output logic [7:0] o_dout
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_din;
        end
    end

    assign o_dout = r_byte;

endmodule

/* hdl/sfcd_chain.sv */
`timescale 1ns / 1ps

module sfcd_chain (
    input  logic                  i_clk,
    input  sfcd_pkg::t_chain_ctl  i_ctl,
    output logic [7:0]            o_tap
);

    logic [7:0] w_link [0:sfcd_pkg::FRAME_LEN];

    assign w_link[0] = i_ctl.din;

    for (genvar g = 0; g < sfcd_pkg::FRAME_LEN; g++) begin : g_cell
        sfcd_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(i_ctl.shift),
            .i_din  (w_link[g]),
            .o_dout (w_link[g+1])
        );
    end

    assign o_tap = w_link[sfcd_pkg::TAP + 1];

endmodule

/* hdl/sync_framed_command_deframer_top.sv */
`timescale 1ns / 1ps
// A status result is registered and offered in the cycle after its byte is accepted.
// Throughput: one byte per cycle while results are taken; a good frame emits
// its command bytes one per cycle from the frame shift chain while results
// are taken, and the next byte is accepted once the last of them is taken.
// Reset is synchronous, active low, and clears the parser, counters and
// output valid; the frame chain holds no reset.

module sync_framed_command_deframer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_status,
    output logic [7:0] o_data_byte,
    output logic [5:0] o_byte_index,
    output logic       o_last,
    output logic [7:0] o_error_count,
    output logic [7:0] o_frame_count
);

    sfcd_pkg::t_state r_state, n_state;
    logic [sfcd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [sfcd_pkg::IDX_W-1:0] r_idx, n_idx;
    logic       r_emit, n_emit;
    logic [7:0] r_err, n_err;
    logic [7:0] r_frames, n_frames;
    logic       r_res_valid, n_res_valid;

    sfcd_pkg::t_status r_status, n_status;
    logic [7:0] r_data, n_data;
    logic [5:0] r_res_idx, n_res_idx;
    logic       r_last, n_last;

    sfcd_pkg::t_chain_ctl w_ctl;
    logic [7:0] w_tap;
    logic       w_out_free;
    logic       w_rx_fire;

    sfcd_chain u_chain (
        .i_clk(i_clk),
        .i_ctl(w_ctl),
        .o_tap(w_tap)
    );

    assign w_out_free = !r_res_valid || i_res_ready;
    assign o_rx_ready = !r_emit && w_out_free;
    assign w_rx_fire  = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_emit      = r_emit;
        n_err       = r_err;
        n_frames    = r_frames;
        n_res_valid = r_res_valid && !i_res_ready;
        n_status    = r_status;
        n_data      = r_data;
        n_res_idx   = r_res_idx;
        n_last      = r_last;
        w_ctl.shift = 1'b0;
        w_ctl.din   = i_rx_byte;

        if (w_rx_fire) begin
            n_res_valid = 1'b1;
            n_status    = sfcd_pkg::STAT_NONE;
            n_data      = 8'd0;
            n_res_idx   = 6'd0;
            n_last      = 1'b1;
            unique case (r_state)
                sfcd_pkg::ST_HUNT: begin
                    if (i_rx_byte == sfcd_pkg::SYNC_A) begin
                        w_ctl.shift = 1'b1;
                        n_pos       = sfcd_pkg::POS_W'(1);
                        n_state     = sfcd_pkg::ST_SYNC2;
                    end
                end
                sfcd_pkg::ST_SYNC2: begin
                    if (i_rx_byte == sfcd_pkg::SYNC_B) begin
                        w_ctl.shift = 1'b1;
                        n_pos       = r_pos + 1'b1;
                        n_state     = sfcd_pkg::ST_BODY;
                    end else begin
                        n_err    = r_err + 8'd1;
                        n_status = sfcd_pkg::STAT_BAD_SYNC;
                        n_pos    = '0;
                        n_state  = sfcd_pkg::ST_HUNT;
                    end
                end
                sfcd_pkg::ST_BODY: begin
                    w_ctl.shift = 1'b1;
                    if (r_pos == sfcd_pkg::POS_TAIL_A) begin
                        if (i_rx_byte == sfcd_pkg::TAIL_A) begin
                            n_pos   = r_pos + 1'b1;
                            n_state = sfcd_pkg::ST_TAIL2;
                        end else begin
                            n_err    = r_err + 8'd1;
                            n_status = sfcd_pkg::STAT_BAD_TAIL1;
                            n_pos    = '0;
                            n_state  = sfcd_pkg::ST_HUNT;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                sfcd_pkg::ST_TAIL2: begin
                    w_ctl.shift = 1'b1;
                    n_pos       = '0;
                    n_state     = sfcd_pkg::ST_HUNT;
                    if (i_rx_byte == sfcd_pkg::TAIL_B) begin
                        n_frames    = r_frames + 8'd1;
                        n_emit      = 1'b1;
                        n_idx       = '0;
                        n_res_valid = 1'b0;
                    end else begin
                        n_err    = r_err + 8'd1;
                        n_status = sfcd_pkg::STAT_BAD_TAIL2;
                    end
                end
                default: begin
                    n_pos   = '0;
                    n_state = sfcd_pkg::ST_HUNT;
                end
            endcase
        end else if (r_emit && w_out_free) begin
            // Zeros enter the chain so that offsets past the frame read as zero.
            w_ctl.shift = 1'b1;
            w_ctl.din   = 8'd0;
            n_res_valid = 1'b1;
            n_status    = sfcd_pkg::STAT_CMD;
            n_data      = w_tap;
            n_res_idx   = 6'(r_idx);
            n_last      = (r_idx == sfcd_pkg::IDX_LAST);
            n_idx       = r_idx + 1'b1;
            if (r_idx == sfcd_pkg::IDX_LAST) begin
                n_emit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfcd_pkg::ST_HUNT;
            r_pos       <= '0;
            r_idx       <= '0;
            r_emit      <= 1'b0;
            r_err       <= 8'd0;
            r_frames    <= 8'd0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_emit      <= n_emit;
            r_err       <= n_err;
            r_frames    <= n_frames;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_data    <= n_data;
        r_res_idx <= n_res_idx;
        r_last    <= n_last;
    end

    assign o_res_valid   = r_res_valid;
    assign o_status      = r_status;
    assign o_data_byte   = r_data;
    assign o_byte_index  = r_res_idx;
    assign o_last        = r_last;
    assign o_error_count = r_err;
    assign o_frame_count = r_frames;

`ifndef NO_ASSERTIONS
    a_emit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> !o_rx_ready)
        else $error("byte accepted while command bytes are being emitted");

    a_emit_in_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> r_state == sfcd_pkg::ST_HUNT)
        else $error("emission active outside hunting");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status != sfcd_pkg::STAT_CMD) |->
            (o_last && o_data_byte == 8'd0 && o_byte_index == 6'd0))
        else $error("status result carries command fields");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("parser state is not one-hot");

    a_frame_bump_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frames != $past(r_frames)) |-> r_emit)
        else $error("frame count moved without command emission");
`endif

endmodule
